// ===== rtl/ddo_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the odometry block.
package ddo_pkg;

	localparam int CordicStepsDefault = 16;
	localparam int CordicStepsMax = 24;
	localparam int StepW = 5;
	localparam int CordicW = 26;
	localparam logic signed [CordicW-1:0] CordicGainInv = 26'sd2547003;
	localparam int PosW = 48;
	localparam int HeadW = 32;
	localparam int SumW = 42;
	localparam int ProdW = SumW + CordicW;
	localparam int DistW = 24;
	localparam int AngW = 32;
	localparam int DiffW = 17;
	localparam int DhW = DiffW + AngW + 1;
	localparam logic [0:0] RegDist = 1'b0;
	localparam logic [0:0] RegAng = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROTATE,
		ST_MULT,
		ST_ACCUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic rotate;
		logic mult;
		logic accum;
	} ddo_cmd_t;

	typedef struct packed {
		logic rot_done;
	} ddo_status_t;

	function automatic logic signed [HeadW:0] atan_lookup(input logic [StepW-1:0] idx);
		logic signed [HeadW:0] v;
		case (idx)
			5'd0: v = 33'sd536870912;
			5'd1: v = 33'sd316933406;
			5'd2: v = 33'sd167458907;
			5'd3: v = 33'sd85004756;
			5'd4: v = 33'sd42667331;
			5'd5: v = 33'sd21354465;
			5'd6: v = 33'sd10679838;
			5'd7: v = 33'sd5340245;
			5'd8: v = 33'sd2670163;
			5'd9: v = 33'sd1335087;
			5'd10: v = 33'sd667544;
			5'd11: v = 33'sd333772;
			5'd12: v = 33'sd166886;
			5'd13: v = 33'sd83443;
			5'd14: v = 33'sd41722;
			5'd15: v = 33'sd20861;
			5'd16: v = 33'sd10430;
			5'd17: v = 33'sd5215;
			5'd18: v = 33'sd2608;
			5'd19: v = 33'sd1304;
			5'd20: v = 33'sd652;
			5'd21: v = 33'sd326;
			5'd22: v = 33'sd163;
			5'd23: v = 33'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/differential_drive_odometry_top.sv =====
// From input accept, an item passes the load, rotate, multiply and accumulate states before the result is valid.
// The iterative CORDIC limits how often a new item can be accepted.
// One item in flight; input ready only while idle; result held until taken.
// arst_n clears pose and heading to zero and loads register defaults.
// Top level of the differential-drive odometry block.
module differential_drive_odometry_top #(
	parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // left_count_delta, right_count_delta
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,  // pose_x_out, pose_y_out, heading_out, saturated
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import ddo_pkg::*;

	ddo_cmd_t cmd;
	ddo_status_t status;
	logic in_fire, out_fire;
	logic [PosW-1:0] x, y;
	logic [HeadW-1:0] h;
	logic sat;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	ddo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.status(status), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
	);

	ddo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_fire(in_fire),
		.left_in(s_axis_tdata[15:0]), .right_in(s_axis_tdata[31:16]),
		.cmd(cmd), .status(status), .x_out(x), .y_out(y), .head_out(h), .sat_out(sat)
	);

	assign m_axis_tdata = {7'b0, sat, h, y, x};

endmodule

// ===== rtl/ddo_ctrl.sv =====
// Controller state machine sequencing load, CORDIC rotation, multiply and update.
module ddo_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic                 out_fire,
	input  ddo_pkg::ddo_status_t status,
	output ddo_pkg::ddo_cmd_t    cmd,
	output logic                 in_ready,
	output logic                 out_valid
);
	import ddo_pkg::*;

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_next = ST_LOAD;
			ST_LOAD: state_next = ST_ROTATE;
			ST_ROTATE: if (status.rot_done) state_next = ST_MULT;
			ST_MULT: state_next = ST_ACCUM;
			ST_ACCUM: state_next = ST_OUT;
			ST_OUT: if (out_fire) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_LOAD: cmd.load = 1'b1;
			ST_ROTATE: cmd.rotate = 1'b1;
			ST_MULT: cmd.mult = 1'b1;
			ST_ACCUM: cmd.accum = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== rtl/ddo_datapath.sv =====
// Datapath: config registers, pose state, iterative CORDIC, multipliers, saturation.
module ddo_datapath #(
	parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      in_fire,
	input  logic signed [15:0]        left_in,
	input  logic signed [15:0]        right_in,
	input  ddo_pkg::ddo_cmd_t         cmd,
	output ddo_pkg::ddo_status_t      status,
	output logic [ddo_pkg::PosW-1:0]  x_out,
	output logic [ddo_pkg::PosW-1:0]  y_out,
	output logic [ddo_pkg::HeadW-1:0] head_out,
	output logic                      sat_out
);
	import ddo_pkg::*;

	localparam logic signed [PosW+1:0] PosMax = {3'b000, {(PosW-1){1'b1}}};
	localparam logic signed [PosW+1:0] PosMin = {3'b111, {(PosW-1){1'b0}}};

	logic [DistW-1:0] dist_q;
	logic [AngW-1:0] ang_q;
	logic signed [PosW-1:0] px_q, py_q;
	logic [HeadW-1:0] head_q;
	logic sat_q;
	logic signed [15:0] l_q, r_q;
	logic signed [SumW-1:0] sum_q;
	logic signed [DhW-1:0] dh_q;
	logic signed [CordicW-1:0] cx_q, cy_q;
	logic signed [HeadW:0] cz_q;
	logic [1:0] quad_q;
	logic [StepW-1:0] step_q;
	logic signed [ProdW-1:0] mx_q, my_q;

	logic signed [CordicW-1:0] xs, ys, cos_v, sin_v;
	logic signed [HeadW:0] atan_v;
	logic signed [PosW+1:0] nx, ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= 24'd65536;
			ang_q <= 32'd16777216;
		end else if (cfg_we) begin
			if (cfg_index == RegDist) dist_q <= cfg_data[DistW-1:0];
			else ang_q <= cfg_data;
		end
	end

	assign xs = cx_q >>> step_q;
	assign ys = cy_q >>> step_q;
	assign atan_v = atan_lookup(step_q);
	assign status.rot_done = (step_q == StepW'(CORDIC_STEPS - 1));

	always_comb begin
		case (quad_q)
			2'd0: begin cos_v = cx_q; sin_v = cy_q; end
			2'd1: begin cos_v = -cy_q; sin_v = cx_q; end
			2'd2: begin cos_v = -cx_q; sin_v = -cy_q; end
			default: begin cos_v = cy_q; sin_v = -cx_q; end
		endcase
	end

	assign nx = PosW'(px_q) + (PosW+2)'(mx_q >>> 24);
	assign ny = PosW'(py_q) + (PosW+2)'(my_q >>> 24);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			l_q <= left_in;
			r_q <= right_in;
		end
		if (cmd.load) begin
			sum_q <= SumW'((17'(l_q) + 17'(r_q)) * $signed({1'b0, dist_q}));
			dh_q <= DhW'((17'(r_q) - 17'(l_q)) * $signed({1'b0, ang_q}));
			cx_q <= CordicGainInv;
			cy_q <= '0;
			cz_q <= {3'b000, head_q[HeadW-3:0]};
			quad_q <= head_q[HeadW-1:HeadW-2];
			step_q <= '0;
		end
		if (cmd.rotate) begin
			if (!cz_q[HeadW]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_v;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_v;
			end
			step_q <= step_q + 1'b1;
		end
		if (cmd.mult) begin
			mx_q <= ProdW'(sum_q) * ProdW'(cos_v);
			my_q <= ProdW'(sum_q) * ProdW'(sin_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			head_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.accum) begin
			px_q <= (nx > PosMax) ? PosMax[PosW-1:0] : (nx < PosMin) ? PosMin[PosW-1:0]
				: nx[PosW-1:0];
			py_q <= (ny > PosMax) ? PosMax[PosW-1:0] : (ny < PosMin) ? PosMin[PosW-1:0]
				: ny[PosW-1:0];
			sat_q <= (nx > PosMax) || (nx < PosMin) || (ny > PosMax) || (ny < PosMin);
			head_q <= head_q + dh_q[HeadW+15:16];
		end
	end

	assign x_out = px_q;
	assign y_out = py_q;
	assign head_out = head_q;
	assign sat_out = sat_q;

endmodule
